>>> hdl/assert_macros.svh
// Assertion macros for the RTL files of the grid health block.
// Include this file where a module carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/gmeh_pkg.sv
// Shared types and constants of the grid minimum entry health block.
// No dependencies; imported by every module of the block.
`default_nettype none

package gmeh_pkg;

   // Fixed widths of the need values and the count registers.
   localparam int NEED_WIDTH  = 25;
   localparam int COUNT_WIDTH = 9;

   // Defaults of the top-level parameters.
   localparam int DEFAULT_MAX_ROWS    = 256;
   localparam int DEFAULT_MAX_COLUMNS = 256;
   localparam int DEFAULT_VALUE_WIDTH = 16;

   // Width of the response data bus, the need padded to whole bytes.
   localparam int RSP_DATA_WIDTH = ((NEED_WIDTH + 7) / 8) * 8;

   // Register indexes of the configuration port.
   typedef enum logic {
      CSR_ROW_COUNT    = 1'b0,
      CSR_COLUMN_COUNT = 1'b1
   } csr_index_type;

   // Position of a cell in the walk, as the need logic sees it.
   typedef struct packed {
      logic bottom;     // cell lies in the last grid row
      logic rightmost;  // cell lies in the last grid column
   } gmeh_pos_type;

endpackage

`default_nettype wire

>>> hdl/gmeh_row_buf.sv
// Row buffer holding the needs of the row below, one entry per column.
// Synchronous memory with a registered read and write-to-read forwarding.
`default_nettype none

module gmeh_row_buf
   import gmeh_pkg::*;
#(
   parameter int DEPTH      = DEFAULT_MAX_COLUMNS,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [NEED_WIDTH-1:0] rd_data,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [NEED_WIDTH-1:0] wr_data
);

   logic [NEED_WIDTH-1:0] mem [DEPTH];
   logic [NEED_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; a write to the same entry in the same cycle is passed through.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/gmeh_need_calc.sv
// Need of one cell from its value and the needs below and to the right.
// Combinational; uses the position type and widths of gmeh_pkg.
`default_nettype none

module gmeh_need_calc
   import gmeh_pkg::*;
#(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  wire logic signed [VALUE_WIDTH-1:0] value,
   input  wire gmeh_pos_type                  pos,
   input  wire logic        [NEED_WIDTH-1:0]  below_need,
   input  wire logic        [NEED_WIDTH-1:0]  right_need,
   output logic             [NEED_WIDTH-1:0]  need
);

   localparam int EXT_WIDTH = NEED_WIDTH + VALUE_WIDTH + 1;

   logic        [NEED_WIDTH-1:0] t;
   logic signed [EXT_WIDTH-1:0]  t_ext;
   logic signed [EXT_WIDTH-1:0]  v_ext;
   logic signed [EXT_WIDTH-1:0]  diff;

   // Smaller of the two neighbor needs, zero at the target cell.
   always_comb begin
      if (pos.bottom && pos.rightmost) begin
         t = '0;
      end else if (pos.bottom) begin
         t = right_need;
      end else if (pos.rightmost) begin
         t = below_need;
      end else begin
         t = (below_need < right_need) ? below_need : right_need;
      end
   end

   assign t_ext = signed'({{(EXT_WIDTH - NEED_WIDTH){1'b0}}, t});
   assign v_ext = signed'({{(EXT_WIDTH - VALUE_WIDTH){value[VALUE_WIDTH-1]}}, value});

   // A zero minimum means one point must remain after the cell.
   always_comb begin
      if (t == '0) begin
         diff = t_ext + EXT_WIDTH'(1) - v_ext;
      end else begin
         diff = t_ext - v_ext;
      end
   end

   // No need when the cell covers the minimum; otherwise saturate the difference.
   always_comb begin
      if (v_ext > t_ext) begin
         need = '0;
      end else if (|diff[EXT_WIDTH-1:NEED_WIDTH]) begin
         need = '1;
      end else begin
         need = diff[NEED_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

>>> hdl/grid_min_entry_health_dp_top.sv
// A grid's result passes the compute stage, then the response register, after its top-left cell is taken.
// Throughput: one cell per cycle unless stalled; the row buffer read and write-back close in one stage.
// The input stalls only while a finished result waits and the next grid also ends.
// Reset (synchronous): counts return to 1, positions and right need to zero.
// The row buffer is not cleared; every entry is written before its value is used.
// Top level of the grid minimum entry health block; uses gmeh_pkg,
// gmeh_row_buf and gmeh_need_calc.
`default_nettype none

`include "assert_macros.svh"

module grid_min_entry_health_dp_top
   import gmeh_pkg::*;
#(
   parameter int MAX_ROWS    = DEFAULT_MAX_ROWS,
   parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
   parameter int REQ_DATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Configuration write port.
   input  wire logic                      csr_we,
   input  wire logic                      csr_index,
   input  wire logic [COUNT_WIDTH-1:0]    csr_wdata,
   // Request channel.
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,  // [VALUE_WIDTH-1:0] cell_value
   // Response channel.
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata   // [24:0] min_points
);

   localparam int ADDR_WIDTH = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   logic [COUNT_WIDTH-1:0] row_count_ff, row_count_in;
   logic [COUNT_WIDTH-1:0] col_count_ff, col_count_in;
   logic [COUNT_WIDTH-1:0] row_pos_ff, row_pos_in;
   logic [COUNT_WIDTH-1:0] col_pos_ff, col_pos_in;
   logic [NEED_WIDTH-1:0]  right_need_ff, right_need_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic signed [VALUE_WIDTH-1:0] s1_value_ff;
   gmeh_pos_type                  s1_pos_ff;
   logic                          s1_last_ff;
   logic [ADDR_WIDTH-1:0]         s1_addr_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [NEED_WIDTH-1:0]     rsp_need_ff;

   logic                  req_fire;
   logic                  s1_fire;
   logic                  stall;
   logic                  col_end;
   logic                  row_end;
   gmeh_pos_type          cur_pos;
   logic [ADDR_WIDTH-1:0] cur_addr;
   logic [NEED_WIDTH-1:0] below_need;
   logic [NEED_WIDTH-1:0] need;

   // Clamps a written count to the range 1 to limit.
   function automatic logic [COUNT_WIDTH-1:0] clamp_count(
      input logic [COUNT_WIDTH-1:0] value,
      input int                     limit
   );
      logic [COUNT_WIDTH-1:0] result;
      if (value == '0) begin
         result = COUNT_WIDTH'(1);
      end else if (int'(value) > limit) begin
         result = COUNT_WIDTH'(limit);
      end else begin
         result = value;
      end
      return result;
   endfunction

   // Handshake and stall control.
   assign stall      = s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_tready;
   assign req_tready = !stall;
   assign req_fire   = req_tvalid && req_tready;
   assign s1_fire    = s1_valid_ff && !stall;

   // Position of the incoming cell.
   assign cur_pos.bottom    = (row_pos_ff == '0);
   assign cur_pos.rightmost = (col_pos_ff == '0);
   assign cur_addr          = ADDR_WIDTH'(col_pos_ff);
   assign col_end           = (col_pos_ff == col_count_ff - COUNT_WIDTH'(1));
   assign row_end           = (row_pos_ff == row_count_ff - COUNT_WIDTH'(1));

   // Configuration registers and walk position.
   always_comb begin
      row_count_in  = row_count_ff;
      col_count_in  = col_count_ff;
      row_pos_in    = row_pos_ff;
      col_pos_in    = col_pos_ff;
      right_need_in = right_need_ff;
      if (s1_fire) begin
         right_need_in = need;
      end
      if (req_fire) begin
         if (col_end) begin
            col_pos_in = '0;
            row_pos_in = row_end ? '0 : row_pos_ff + COUNT_WIDTH'(1);
         end else begin
            col_pos_in = col_pos_ff + COUNT_WIDTH'(1);
         end
      end
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ROW_COUNT: begin
               row_count_in = clamp_count(csr_wdata, MAX_ROWS);
            end
            CSR_COLUMN_COUNT: begin
               col_count_in = clamp_count(csr_wdata, MAX_COLUMNS);
            end
            default: begin
               row_count_in = row_count_ff;
            end
         endcase
         row_pos_in    = '0;
         col_pos_in    = '0;
         right_need_in = '0;
      end
   end

   // Compute stage and response register control.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff  <= COUNT_WIDTH'(1);
         col_count_ff  <= COUNT_WIDTH'(1);
         row_pos_ff    <= '0;
         col_pos_ff    <= '0;
         right_need_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         row_count_ff  <= row_count_in;
         col_count_ff  <= col_count_in;
         row_pos_ff    <= row_pos_in;
         col_pos_ff    <= col_pos_in;
         right_need_ff <= right_need_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload of the compute stage and the response.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_value_ff <= signed'(req_tdata[VALUE_WIDTH-1:0]);
         s1_pos_ff   <= cur_pos;
         s1_last_ff  <= col_end && row_end;
         s1_addr_ff  <= cur_addr;
      end
      if (s1_fire && s1_last_ff) begin
         rsp_need_ff <= (need == '0) ? NEED_WIDTH'(1) : need;
      end
   end

   // Row buffer: read at request, written back when the cell leaves the stage.
   gmeh_row_buf #(
      .DEPTH      (MAX_COLUMNS),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_row_buf (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (cur_addr),
      .rd_data (below_need),
      .wr_en   (s1_fire),
      .wr_addr (s1_addr_ff),
      .wr_data (need)
   );

   gmeh_need_calc #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_need_calc (
      .value      (s1_value_ff),
      .pos        (s1_pos_ff),
      .below_need (below_need),
      .right_need (right_need_ff),
      .need       (need)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - NEED_WIDTH){1'b0}}, rsp_need_ff};

   // A finished grid always leaves a result in the response register.
   `ASSERT_CLK(a_last_sets_rsp, clock, reset, s1_fire && s1_last_ff |=> rsp_valid_ff,
      "result of a finished grid was not registered")
   // Positions stay inside the configured grid.
   `ASSERT_CLK(a_col_in_range, clock, reset, col_pos_ff < col_count_ff,
      "column position beyond column count")
   `ASSERT_CLK(a_row_in_range, clock, reset, row_pos_ff < row_count_ff,
      "row position beyond row count")
   // A stalled cell keeps its place and value in the compute stage.
   `ASSERT_CLK(a_stall_holds, clock, reset,
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_value_ff),
      "stalled cell lost from the compute stage")

endmodule

`default_nettype wire

>>> sim/grid_min_entry_health_dp_top_test.sv
// Self-checking testbench for the grid minimum entry health block.
// Directed and random grids stream in; a local copy of the walk predicts each least start value.
// Depends on gmeh_pkg and grid_min_entry_health_dp_top only.
`timescale 1ns / 1ps

module grid_min_entry_health_dp_top_test;
   import gmeh_pkg::*;

   localparam int GRID_ROWS_MAX    = DEFAULT_MAX_ROWS;
   localparam int GRID_COLUMNS_MAX = DEFAULT_MAX_COLUMNS;
   localparam int CELL_WIDTH       = DEFAULT_VALUE_WIDTH;
   localparam int CELL_BUS_WIDTH   = ((CELL_WIDTH + 7) / 8) * 8;
   localparam longint NEED_LIMIT   = (longint'(1) << NEED_WIDTH) - 1;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_CELLS     = 1700;
   localparam int REPORT_LIMIT     = 10;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic                      csr_index = CSR_ROW_COUNT;
   logic [COUNT_WIDTH-1:0]    csr_wdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [CELL_BUS_WIDTH-1:0] req_tdata = '0;  // [15:0] cell_value
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;       // [24:0] min_points

   grid_min_entry_health_dp_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Cells waiting to be sent, and least start values still owed by the block.
   logic [CELL_WIDTH-1:0] pending_cells[$];
   logic [NEED_WIDTH-1:0] owed_points[$];
   int mismatch_count = 0;

   // Walk state of the predictor.
   int rows_used = 1;
   int columns_used = 1;
   int row_pos = 0;
   int column_pos = 0;
   logic [NEED_WIDTH-1:0] right_need = '0;
   logic [NEED_WIDTH-1:0] below_need[GRID_COLUMNS_MAX];

   int cell_gap = 0;
   int cell_calm = 0;
   int result_gap = 0;
   int result_calm = 0;

   // A count of zero means one, and a count above the grid maximum saturates.
   function automatic int clamp_count(logic [COUNT_WIDTH-1:0] raw, int limit);
      if (raw == '0) return 1;
      if (int'(raw) > limit) return limit;
      return int'(raw);
   endfunction

   // Wait before the next request or result; now and then a run without any wait.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 60);
      return $urandom_range(0, 7);
   endfunction

   // Cell values lean toward negative ones so that needs grow along the walk.
   function automatic logic [CELL_WIDTH-1:0] pick_cell_value();
      logic [CELL_WIDTH-1:0] value;
      case ($urandom_range(0, 7))
         0: value = {1'b1, {(CELL_WIDTH-1){1'b0}}};
         1: value = {1'b0, {(CELL_WIDTH-1){1'b1}}};
         2, 3: value = CELL_WIDTH'(int'($urandom_range(0, 40)) - 20);
         4, 5: value = CELL_WIDTH'(-int'($urandom_range(0, 2000)));
         default: value = CELL_WIDTH'($urandom());
      endcase
      return value;
   endfunction

   // One cell of the walk: need from the smaller of the needs below and to the right.
   task automatic advance_walk(logic [CELL_WIDTH-1:0] raw);
      longint cell_val;
      longint floor_need;
      longint below;
      longint right;
      longint need;
      int col;
      cell_val = longint'($signed(raw));
      col = column_pos % GRID_COLUMNS_MAX;
      below = longint'(below_need[col]);
      right = longint'(right_need);
      if (row_pos == 0 && column_pos == 0) floor_need = 0;
      else if (row_pos == 0) floor_need = right;
      else if (column_pos == 0) floor_need = below;
      else floor_need = (below < right) ? below : right;

      if (cell_val > floor_need) need = 0;
      else if (floor_need == 0) need = 1 - cell_val;
      else need = floor_need - cell_val;
      if (need > NEED_LIMIT) need = NEED_LIMIT;

      below_need[col] = NEED_WIDTH'(need);
      right_need = NEED_WIDTH'(need);
      column_pos++;
      if (column_pos >= columns_used) begin
         column_pos = 0;
         row_pos++;
         if (row_pos >= rows_used) begin
            // The top-left cell closes the grid; a zero need still takes one point.
            row_pos = 0;
            right_need = '0;
            owed_points.push_back(need == 0 ? NEED_WIDTH'(1) : NEED_WIDTH'(need));
         end
      end
   endtask

   // Request driver: one request at a time from the pending queue, with random gaps.
   always @(posedge clock) begin : cell_driver
      logic hold;
      if (reset) begin
         req_tvalid <= 1'b0;
         cell_gap = 0;
      end else begin
         hold = req_tvalid && !req_tready;
         if (!hold) begin
            if (cell_gap > 0) begin
               cell_gap--;
            end else if (pending_cells.size() != 0) begin
               req_tdata <= CELL_BUS_WIDTH'(pending_cells.pop_front());
               cell_gap = draw_wait(cell_calm);
               hold = 1'b1;
            end
         end
         req_tvalid <= hold;
      end
   end

   // Result side: a random wait, maybe none, after each result, and sometimes while nothing is offered.
   always @(posedge clock) begin : result_sink
      if (reset) begin
         rsp_tready <= 1'b0;
         result_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) result_gap = draw_wait(result_calm);
         else if (!rsp_tvalid && result_gap == 0 && $urandom_range(0, 7) == 0)
            result_gap = $urandom_range(1, 7);
         if (result_gap > 0) begin
            result_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: predict on each accepted request, then check each accepted result.
   always @(posedge clock) begin : walk_monitor
      logic [NEED_WIDTH-1:0] wanted;
      if (!reset) begin
         if (req_tvalid && req_tready) advance_walk(req_tdata[CELL_WIDTH-1:0]);
         if (rsp_tvalid && rsp_tready) begin
            if (owed_points.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected result: min_points %0d", rsp_tdata[NEED_WIDTH-1:0]);
            end else begin
               wanted = owed_points.pop_front();
               if (rsp_tdata[NEED_WIDTH-1:0] !== wanted) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("min_points mismatch: expected %0d, actual %0d",
                              wanted, rsp_tdata[NEED_WIDTH-1:0]);
               end
            end
         end
      end
   end

   // Wait until every request is taken and every result is in, then let the block drain.
   task automatic settle();
      @(negedge clock);
      while (pending_cells.size() != 0 || req_tvalid || owed_points.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write one count register; any write restarts the walk.
   task automatic write_count(csr_index_type index, logic [COUNT_WIDTH-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (index == CSR_ROW_COUNT) rows_used = clamp_count(value, GRID_ROWS_MAX);
      else columns_used = clamp_count(value, GRID_COLUMNS_MAX);
      row_pos = 0;
      column_pos = 0;
      right_need = '0;
   endtask

   task automatic set_grid(logic [COUNT_WIDTH-1:0] rows_raw, logic [COUNT_WIDTH-1:0] cols_raw);
      settle();
      write_count(CSR_ROW_COUNT, rows_raw);
      write_count(CSR_COLUMN_COUNT, cols_raw);
   endtask

   // Cycle limit against a hung handshake.
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("grid_min_entry_health_dp_top_test failed");
      $finish;
   end

   initial begin : stimulus
      int random_cells;
      int phase;
      int rows_raw;
      int cols_raw;
      int area;
      int grids;
      int cut;
      for (int i = 0; i < GRID_COLUMNS_MAX; i++) below_need[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset counts give a single-cell grid: extremes, zero and one either side.
      pending_cells.push_back(16'sd32767);
      pending_cells.push_back(-16'sd32768);
      pending_cells.push_back(16'sd0);
      pending_cells.push_back(16'sd1);
      pending_cells.push_back(-16'sd1);

      // Two by two grids: the right need smaller, the need below smaller,
      // and a first cell large enough to need nothing.
      set_grid(9'd2, 9'd2);
      pending_cells.push_back(-16'sd5);
      pending_cells.push_back(-16'sd10);
      pending_cells.push_back(-16'sd2);
      pending_cells.push_back(16'sd3);
      pending_cells.push_back(-16'sd5);
      pending_cells.push_back(-16'sd1);
      pending_cells.push_back(-16'sd20);
      pending_cells.push_back(16'sd0);
      pending_cells.push_back(16'sd100);
      pending_cells.push_back(-16'sd3);
      pending_cells.push_back(-16'sd3);
      pending_cells.push_back(16'sd50);

      // A grid cut short by a register write, then zero counts acting as one.
      pending_cells.push_back(-16'sd7);
      pending_cells.push_back(-16'sd9);
      pending_cells.push_back(16'sd4);
      set_grid(9'd0, 9'd0);
      pending_cells.push_back(-16'sd40);
      pending_cells.push_back(16'sd12);

      // Random phases: the longest column, the widest row, then mostly small grids.
      random_cells = 0;
      phase = 0;
      while (random_cells < RANDOM_CELLS) begin
         if (phase == 0) begin
            rows_raw = GRID_ROWS_MAX;
            cols_raw = 1;
         end else if (phase == 1) begin
            rows_raw = 1;
            cols_raw = (1 << COUNT_WIDTH) - 1;
         end else begin
            case ($urandom_range(0, 9))
               0: rows_raw = 0;
               7, 8: rows_raw = $urandom_range(7, 20);
               9: rows_raw = $urandom_range(21, 64);
               default: rows_raw = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 9))
               0: cols_raw = 0;
               7, 8: cols_raw = $urandom_range(7, 20);
               9: cols_raw = $urandom_range(21, 64);
               default: cols_raw = $urandom_range(1, 6);
            endcase
            if (clamp_count(COUNT_WIDTH'(rows_raw), GRID_ROWS_MAX) *
                clamp_count(COUNT_WIDTH'(cols_raw), GRID_COLUMNS_MAX) > 400)
               cols_raw = $urandom_range(1, 4);
         end
         set_grid(COUNT_WIDTH'(rows_raw), COUNT_WIDTH'(cols_raw));
         area = clamp_count(COUNT_WIDTH'(rows_raw), GRID_ROWS_MAX) *
                clamp_count(COUNT_WIDTH'(cols_raw), GRID_COLUMNS_MAX);
         grids = (area >= 120) ? 1 : 120 / area;
         for (int g = 0; g < grids * area; g++) pending_cells.push_back(pick_cell_value());
         random_cells += grids * area;
         // Sometimes leave a grid unfinished before the next register write.
         if (area > 1 && $urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, area - 1);
            for (int c = 0; c < cut; c++) pending_cells.push_back(pick_cell_value());
            random_cells += cut;
         end
         phase++;
      end

      settle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && owed_points.size() == 0) begin
         $display("grid_min_entry_health_dp_top_test passed");
      end else begin
         $display("grid_min_entry_health_dp_top_test failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/gmeh_pkg.sv
hdl/gmeh_row_buf.sv
hdl/gmeh_need_calc.sv
hdl/grid_min_entry_health_dp_top.sv
sim/grid_min_entry_health_dp_top_test.sv
